@@ design/lfw_pkg.sv @@
package lfw_pkg;

  localparam int unsigned IDX_W       = 7;
  localparam int unsigned TABLE_SLOTS = 1 << IDX_W;
  localparam int unsigned FRAC_W      = 53;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned SEED_W      = 64;
  localparam int unsigned X_W         = 32;
  localparam int unsigned BIT_W       = $clog2(FRAC_W);
  localparam int unsigned SEED_BIT    = 5;

  localparam int unsigned LONG_LAG_DEF  = 98;
  localparam int unsigned SHORT_LAG_DEF = 33;

  localparam logic [FRAC_W-1:0] WEYL_STEP = 53'd5566755282872655;
  localparam logic [FRAC_W-1:0] WEYL_MOD  = 53'd9007199254740881;
  localparam logic [FRAC_W-1:0] WEYL_WRAP = WEYL_MOD - WEYL_STEP;

  localparam int unsigned X_MULT = 6969;
  localparam int unsigned X_MOD  = 65543;
  localparam int unsigned Y_MULT = 8888;
  localparam int unsigned Y_MOD  = 65579;

  // action codes
  localparam logic ACT_RESEED = 1'b0;
  localparam logic ACT_NEXT   = 1'b1;

  // phases of one generator step during reseed
  localparam int unsigned PH_W = 2;
  localparam logic [PH_W-1:0] PH_MUL  = 2'd0;
  localparam logic [PH_W-1:0] PH_RCP  = 2'd1;
  localparam logic [PH_W-1:0] PH_FOLD = 2'd2;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  addr;
    logic [FRAC_W-1:0] data;
  } lfw_wr_t;

endpackage

@@ design/lfw_in_if.sv @@
interface lfw_in_if import lfw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [SEED_W-1:0] seed;

  modport source (output valid, output action, output seed, input ready);
  modport sink (input valid, input action, input seed, output ready);
endinterface

@@ design/lfw_out_if.sv @@
interface lfw_out_if import lfw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink (input valid, input random_word, output ready);
endinterface

@@ design/lagged_fibonacci_weyl_prng.sv @@
// Lagged Fibonacci generator with a Weyl sequence, 53-bit fractions.
// Input channel req_i carries action and seed. action = next asks for one
// word; it is registered after the table read and then in the output or
// skid register before it appears on rsp_o. Next items are taken one per
// cycle while the receiver takes words: the lag table sits in a memory
// read at both lags in the accept cycle and written back in the following
// one, with the just-written entry forwarded to a read that hits it.
// action = reseed gives no word. It refills entries 1..LONG_LAG, one bit
// per step of the two small generators (multiply, reciprocal estimate,
// fold); req_i.ready stays low after the accept until the refill ends.
// Words sit in an output register backed by one skid register; while the
// receiver stalls, req_i.ready drops once both would be occupied.
// After reset the table reads as all zeros through per-entry valid flags,
// so no clearing pass runs; the Weyl value is zero and the indices sit at
// LONG_LAG and SHORT_LAG. Next items before any reseed are served at once.
module lagged_fibonacci_weyl_prng import lfw_pkg::*; #(
  parameter int unsigned LONG_LAG  = LONG_LAG_DEF,
  parameter int unsigned SHORT_LAG = SHORT_LAG_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  lfw_in_if.sink    req_i,
  lfw_out_if.source rsp_o
);

  localparam logic [IDX_W-1:0] LONG_IDX  = IDX_W'(LONG_LAG);
  localparam logic [IDX_W-1:0] SHORT_IDX = IDX_W'(SHORT_LAG);

  function automatic logic [IDX_W-1:0] step_idx(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] res;
    if (idx <= IDX_W'(1)) res = LONG_IDX;
    else res = idx - IDX_W'(1);
    return res;
  endfunction

  logic [FRAC_W-1:0]      mem [TABLE_SLOTS];
  logic [TABLE_SLOTS-1:0] val_q;

  logic [IDX_W-1:0]  li_q, si_q;
  logic [FRAC_W-1:0] weyl_q, weyl_d;
  logic              acc, acc_next, acc_seed;
  logic              seed_busy;
  lfw_wr_t           seed_wr;
  lfw_wr_t           mem_wr;

  logic              s1_valid_q;
  logic [IDX_W-1:0]  s1_li_q, s1_si_q;
  logic [FRAC_W-1:0] rd_l_q, rd_s_q;
  logic              vl_q, vs_q;

  logic              fwd_valid_q;
  logic [IDX_W-1:0]  fwd_addr_q;
  logic [FRAC_W-1:0] fwd_data_q;

  logic [FRAC_W-1:0] u_l, u_s, d, comb;
  logic [WORD_W-1:0] word;

  logic              out_valid_q, out_valid_d;
  logic              skid_valid_q, skid_valid_d;
  logic [WORD_W-1:0] out_word_q, out_word_d;
  logic [WORD_W-1:0] skid_word_q, skid_word_d;
  logic              pop;
  logic [1:0]        occ;

  lfw_seeder #(.LONG_LAG(LONG_LAG)) u_seeder (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (acc_seed),
    .seed_i  (req_i.seed),
    .busy_o  (seed_busy),
    .wr_o    (seed_wr)
  );

  // handshake: room for the word in flight and one more
  always_comb begin
    pop         = out_valid_q && rsp_o.ready;
    occ         = 2'(out_valid_q) + 2'(skid_valid_q) + 2'(s1_valid_q) - 2'(pop);
    req_i.ready = !seed_busy && (occ <= 2'd1);
    acc         = req_i.valid && req_i.ready;
    acc_next    = acc && (req_i.action == ACT_NEXT);
    acc_seed    = acc && (req_i.action == ACT_RESEED);
  end

  always_comb begin
    if (weyl_q >= WEYL_STEP) weyl_d = weyl_q - WEYL_STEP;
    else weyl_d = weyl_q + WEYL_WRAP;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      li_q   <= LONG_IDX;
      si_q   <= SHORT_IDX;
      weyl_q <= '0;
    end else if (acc_seed) begin
      li_q   <= LONG_IDX;
      si_q   <= SHORT_IDX;
      weyl_q <= '0;
    end else if (acc_next) begin
      li_q   <= step_idx(li_q);
      si_q   <= step_idx(si_q);
      weyl_q <= weyl_d;
    end
  end

  // after the read: subtract with forwarding of last cycle's write
  always_comb begin
    if (fwd_valid_q && (fwd_addr_q == s1_li_q)) u_l = fwd_data_q;
    else u_l = vl_q ? rd_l_q : '0;
    if (fwd_valid_q && (fwd_addr_q == s1_si_q)) u_s = fwd_data_q;
    else u_s = vs_q ? rd_s_q : '0;
    d    = u_l - u_s;
    comb = d - weyl_q;
    word = comb[FRAC_W-1 -: WORD_W];
  end

  always_comb begin
    if (s1_valid_q) begin
      mem_wr.we   = 1'b1;
      mem_wr.addr = s1_li_q;
      mem_wr.data = d;
    end else begin
      mem_wr = seed_wr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_wr.we) begin
      mem[mem_wr.addr] <= mem_wr.data;
    end
    if (acc_next) begin
      rd_l_q  <= mem[li_q];
      rd_s_q  <= mem[si_q];
      vl_q    <= val_q[li_q];
      vs_q    <= val_q[si_q];
      s1_li_q <= li_q;
      s1_si_q <= si_q;
    end
    fwd_addr_q <= s1_li_q;
    fwd_data_q <= d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q       <= '0;
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else begin
      if (mem_wr.we) begin
        val_q[mem_wr.addr] <= 1'b1;
      end
      s1_valid_q  <= acc_next;
      fwd_valid_q <= s1_valid_q;
    end
  end

  // output register plus skid
  always_comb begin
    out_valid_d  = out_valid_q;
    out_word_d   = out_word_q;
    skid_valid_d = skid_valid_q;
    skid_word_d  = skid_word_q;
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_word_d   = skid_word_q;
        skid_valid_d = s1_valid_q;
        skid_word_d  = word;
      end else begin
        out_valid_d = s1_valid_q;
        out_word_d  = word;
      end
    end else if (s1_valid_q) begin
      skid_valid_d = 1'b1;
      skid_word_d  = word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q  <= out_word_d;
    skid_word_q <= skid_word_d;
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.random_word = out_word_q;

  a_wr_port_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s1_valid_q && seed_wr.we))
    else $error("table write port contended");

  a_word_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |=> out_valid_q)
    else $error("word lost after table step");

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a word while output register is empty");

  a_seed_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seed_wr.we |-> (seed_wr.addr != '0) && (seed_wr.addr <= LONG_IDX))
    else $error("reseed writes outside lag range");

  a_no_next_while_seeding: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seed_busy |-> !s1_valid_q || !$past(seed_busy))
    else $error("next step in flight during reseed");

endmodule

@@ design/lfw_mcg.sv @@
module lfw_mcg import lfw_pkg::*; #(
  parameter int unsigned MULT    = X_MULT,
  parameter int unsigned MODULUS = X_MOD
) (
  input  logic                       clk_i,
  input  logic                       load_i,
  input  logic [X_W-1:0]             seed_i,
  input  logic                       en_i,
  input  logic [PH_W-1:0]            ph_i,
  output logic [$clog2(MODULUS)-1:0] next_o
);

  localparam logic [2*X_W-1:0] RECIP = (64'd1 << X_W) / MODULUS;
  localparam int unsigned      Q_W   = $clog2(RECIP + 1);
  localparam int unsigned      R_W   = $clog2(MODULUS);
  localparam logic [X_W-1:0]   MOD_C = X_W'(MODULUS);
  localparam logic [X_W-1:0]   MUL_C = X_W'(MULT);

  logic [X_W-1:0]     x_q;
  logic [X_W-1:0]     p_q;
  logic [Q_W-1:0]     q_q;
  logic [X_W-1:0]     p_d;
  logic [2*X_W-1:0]   rcp_prod;
  logic [X_W-1:0]     qk;
  logic [X_W-1:0]     r0;
  logic [X_W-1:0]     r;

  always_comb begin
    p_d      = x_q * MUL_C;
    // quotient estimate is low by at most one
    rcp_prod = {{X_W{1'b0}}, p_q} * RECIP;
    qk       = X_W'(q_q) * MOD_C;
    r0       = p_q - qk;
    r        = (r0 >= MOD_C) ? r0 - MOD_C : r0;
    next_o   = r[R_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      x_q <= seed_i;
    end else if (en_i) begin
      case (ph_i)
        PH_MUL:  p_q <= p_d;
        PH_RCP:  q_q <= rcp_prod[X_W +: Q_W];
        PH_FOLD: x_q <= r;
        default: ;
      endcase
    end
  end

endmodule

@@ design/lfw_seeder.sv @@
module lfw_seeder import lfw_pkg::*; #(
  parameter int unsigned LONG_LAG = LONG_LAG_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SEED_W-1:0] seed_i,
  output logic              busy_o,
  output lfw_wr_t           wr_o
);

  localparam logic [BIT_W-1:0] LAST_BIT   = BIT_W'(FRAC_W - 1);
  localparam logic [IDX_W-1:0] LAST_ENTRY = IDX_W'(LONG_LAG);

  logic                  busy_q, busy_d;
  logic [PH_W-1:0]       ph_q, ph_d;
  logic [BIT_W-1:0]      bit_q, bit_d;
  logic [IDX_W-1:0]      entry_q, entry_d;
  logic [FRAC_W-2:0]     frac_q;
  logic [FRAC_W-1:0]     frac_full;
  logic [$clog2(X_MOD)-1:0] nx;
  logic [$clog2(Y_MOD)-1:0] ny;
  logic                  rnd_bit;

  lfw_mcg #(.MULT(X_MULT), .MODULUS(X_MOD)) u_mcg_x (
    .clk_i  (clk_i),
    .load_i (start_i),
    .seed_i (seed_i[X_W-1:0]),
    .en_i   (busy_q),
    .ph_i   (ph_q),
    .next_o (nx)
  );

  lfw_mcg #(.MULT(Y_MULT), .MODULUS(Y_MOD)) u_mcg_y (
    .clk_i  (clk_i),
    .load_i (start_i),
    .seed_i (seed_i[SEED_W-1:X_W]),
    .en_i   (busy_q),
    .ph_i   (ph_q),
    .next_o (ny)
  );

  always_comb begin
    rnd_bit   = nx[SEED_BIT] ^ ny[SEED_BIT];
    frac_full = {frac_q, rnd_bit};
    wr_o.we   = busy_q && (ph_q == PH_FOLD) && (bit_q == LAST_BIT);
    wr_o.addr = entry_q;
    wr_o.data = frac_full;
    busy_o    = busy_q;
  end

  always_comb begin
    busy_d  = busy_q;
    ph_d    = ph_q;
    bit_d   = bit_q;
    entry_d = entry_q;
    if (start_i) begin
      busy_d  = 1'b1;
      ph_d    = PH_MUL;
      bit_d   = '0;
      entry_d = IDX_W'(1);
    end else if (busy_q) begin
      case (ph_q)
        PH_MUL:  ph_d = PH_RCP;
        PH_RCP:  ph_d = PH_FOLD;
        PH_FOLD: begin
          ph_d = PH_MUL;
          if (bit_q == LAST_BIT) begin
            bit_d   = '0;
            entry_d = entry_q + IDX_W'(1);
            if (entry_q == LAST_ENTRY) begin
              busy_d = 1'b0;
            end
          end else begin
            bit_d = bit_q + BIT_W'(1);
          end
        end
        default: ph_d = PH_MUL;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      ph_q    <= PH_MUL;
      bit_q   <= '0;
      entry_q <= IDX_W'(1);
    end else begin
      busy_q  <= busy_d;
      ph_q    <= ph_d;
      bit_q   <= bit_d;
      entry_q <= entry_d;
    end
  end

  // bits come in most significant first
  always_ff @(posedge clk_i) begin
    if (busy_q && (ph_q == PH_FOLD)) begin
      frac_q <= frac_full[FRAC_W-2:0];
    end
  end

endmodule
